[src/gdsp_pkg.sv]
// ----------------------------------------------------------------------------
// gdsp_pkg: shared types and codes for the grid shortest-path core
// Word layouts, command/kind/status codes and the controller-datapath link.
// ----------------------------------------------------------------------------
package gdsp_pkg;

  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 64;

  // configuration port
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'd1;

  // item commands
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_RUN   = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  // cell kinds
  localparam logic [1:0] KIND_ONE     = 2'd0;
  localparam logic [1:0] KIND_TWO     = 2'd1;
  localparam logic [1:0] KIND_BLOCKED = 2'd2;

  // result status
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_RANGE  = 2'd1;
  localparam logic [1:0] ST_NO_RUN = 2'd2;

  localparam int          DIST_OUT_W = 14;
  localparam logic [13:0] DIST_SAT   = 14'h3FFF;
  localparam logic [2:0]  PRED_NONE  = 3'd0;

  typedef struct packed {
    logic [1:0] cmd;
    logic [5:0] row;
    logic [5:0] col;
    logic [1:0] cell_kind;
  } item_t;

  typedef struct packed {
    logic [1:0]            status;
    logic                  reachable;
    logic [DIST_OUT_W-1:0] distance;
    logic [2:0]            pred_dir;
  } result_t;

  // datapath operations
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_IDLE      = 5'd0;
  localparam logic [OP_W-1:0] OP_RES_ZERO  = 5'd1;
  localparam logic [OP_W-1:0] OP_RES_ST1   = 5'd2;
  localparam logic [OP_W-1:0] OP_RES_ST2   = 5'd3;
  localparam logic [OP_W-1:0] OP_LOAD      = 5'd4;
  localparam logic [OP_W-1:0] OP_KCLR      = 5'd5;
  localparam logic [OP_W-1:0] OP_RCLR      = 5'd6;
  localparam logic [OP_W-1:0] OP_START_RD  = 5'd7;
  localparam logic [OP_W-1:0] OP_START_SET = 5'd8;
  localparam logic [OP_W-1:0] OP_POP_RD    = 5'd9;
  localparam logic [OP_W-1:0] OP_POP_TOP   = 5'd10;
  localparam logic [OP_W-1:0] OP_POP_LAST  = 5'd11;
  localparam logic [OP_W-1:0] OP_SD_RDL    = 5'd12;
  localparam logic [OP_W-1:0] OP_SD_RDR    = 5'd13;
  localparam logic [OP_W-1:0] OP_SD_STEP   = 5'd14;
  localparam logic [OP_W-1:0] OP_HEAP_FIN  = 5'd15;
  localparam logic [OP_W-1:0] OP_NB_RD     = 5'd16;
  localparam logic [OP_W-1:0] OP_NB_UPD    = 5'd17;
  localparam logic [OP_W-1:0] OP_SU_RD     = 5'd18;
  localparam logic [OP_W-1:0] OP_SU_STEP   = 5'd19;
  localparam logic [OP_W-1:0] OP_DIR_NEXT  = 5'd20;
  localparam logic [OP_W-1:0] OP_Q_RD      = 5'd21;
  localparam logic [OP_W-1:0] OP_Q_CAP     = 5'd22;
  localparam logic [OP_W-1:0] OP_QN_CMP    = 5'd23;
  localparam logic [OP_W-1:0] OP_OUT       = 5'd24;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            take;   // input word accepted this cycle
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       range_ok;
    logic       search_done;
    logic       clr_last;
    logic       blocked;
    logic       heap_empty;
    logic       heap_one;
    logic       sd_no_l;
    logic       sd_move;
    logic       nb_valid;
    logic       nb_push;
    logic       su_root;
    logic       su_move;
    logic       dir_last;
    logic       q_hit_end;
    logic       qn_match;
    logic       out_busy;
  } dp_status_t;

endpackage

[src/gdsp_ram.sv]
// ----------------------------------------------------------------------------
// gdsp_ram: generic single-port RAM
// One address per cycle, write or read, read data registered (read-first).
// ----------------------------------------------------------------------------
module gdsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[src/gdsp_ctrl.sv]
// ----------------------------------------------------------------------------
// gdsp_ctrl: sequencer for the grid shortest-path core
// Steps load, run (clear, heap pop, sift, neighbour relax) and query.
// ----------------------------------------------------------------------------
module gdsp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  gdsp_pkg::dp_status_t st,
  output gdsp_pkg::dp_cmd_t    ctl
);

  localparam logic [4:0] S_KCLR      = 5'd0;
  localparam logic [4:0] S_IDLE      = 5'd1;
  localparam logic [4:0] S_DISP      = 5'd2;
  localparam logic [4:0] S_RCLR      = 5'd3;
  localparam logic [4:0] S_START_RD  = 5'd4;
  localparam logic [4:0] S_START_SET = 5'd5;
  localparam logic [4:0] S_POP_RD    = 5'd6;
  localparam logic [4:0] S_POP_TOP   = 5'd7;
  localparam logic [4:0] S_POP_LAST  = 5'd8;
  localparam logic [4:0] S_SD_RDL    = 5'd9;
  localparam logic [4:0] S_SD_RDR    = 5'd10;
  localparam logic [4:0] S_SD_STEP   = 5'd11;
  localparam logic [4:0] S_SD_FIN    = 5'd12;
  localparam logic [4:0] S_NB_RD     = 5'd13;
  localparam logic [4:0] S_NB_UPD    = 5'd14;
  localparam logic [4:0] S_SU_RD     = 5'd15;
  localparam logic [4:0] S_SU_STEP   = 5'd16;
  localparam logic [4:0] S_SU_FIN    = 5'd17;
  localparam logic [4:0] S_NB_NEXT   = 5'd18;
  localparam logic [4:0] S_Q_CAP     = 5'd19;
  localparam logic [4:0] S_QN_RD     = 5'd20;
  localparam logic [4:0] S_QN_CMP    = 5'd21;
  localparam logic [4:0] S_QN_NEXT   = 5'd22;
  localparam logic [4:0] S_OUT       = 5'd23;

  logic [4:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_KCLR;
    end else begin
      state <= state_next;
    end
  end

  assign item_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    ctl.op     = gdsp_pkg::OP_IDLE;
    ctl.take   = 1'b0;
    unique case (state)
      S_KCLR: begin
        ctl.op = gdsp_pkg::OP_KCLR;
        if (st.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        ctl.take = item_valid;
        if (item_valid) state_next = S_DISP;
      end
      S_DISP: begin
        priority if (st.cmd == gdsp_pkg::CMD_NONE) begin
          ctl.op = gdsp_pkg::OP_RES_ZERO;
          state_next = S_OUT;
        end else if (!st.range_ok) begin
          ctl.op = gdsp_pkg::OP_RES_ST1;
          state_next = S_OUT;
        end else if (st.cmd == gdsp_pkg::CMD_LOAD) begin
          ctl.op = gdsp_pkg::OP_LOAD;
          state_next = S_OUT;
        end else if (st.cmd == gdsp_pkg::CMD_RUN) begin
          ctl.op = gdsp_pkg::OP_RES_ZERO;
          state_next = S_RCLR;
        end else if (!st.search_done) begin
          ctl.op = gdsp_pkg::OP_RES_ST2;
          state_next = S_OUT;
        end else begin
          ctl.op = gdsp_pkg::OP_Q_RD;
          state_next = S_Q_CAP;
        end
      end
      S_RCLR: begin
        ctl.op = gdsp_pkg::OP_RCLR;
        if (st.clr_last) state_next = S_START_RD;
      end
      S_START_RD: begin
        ctl.op = gdsp_pkg::OP_START_RD;
        state_next = S_START_SET;
      end
      S_START_SET: begin
        ctl.op = gdsp_pkg::OP_START_SET;
        state_next = st.blocked ? S_OUT : S_POP_RD;
      end
      S_POP_RD: begin
        ctl.op = gdsp_pkg::OP_POP_RD;
        state_next = st.heap_empty ? S_OUT : S_POP_TOP;
      end
      S_POP_TOP: begin
        ctl.op = gdsp_pkg::OP_POP_TOP;
        state_next = st.heap_one ? S_NB_RD : S_POP_LAST;
      end
      S_POP_LAST: begin
        ctl.op = gdsp_pkg::OP_POP_LAST;
        state_next = S_SD_RDL;
      end
      S_SD_RDL: begin
        ctl.op = gdsp_pkg::OP_SD_RDL;
        state_next = st.sd_no_l ? S_SD_FIN : S_SD_RDR;
      end
      S_SD_RDR: begin
        ctl.op = gdsp_pkg::OP_SD_RDR;
        state_next = S_SD_STEP;
      end
      S_SD_STEP: begin
        ctl.op = gdsp_pkg::OP_SD_STEP;
        state_next = st.sd_move ? S_SD_RDL : S_SD_FIN;
      end
      S_SD_FIN: begin
        ctl.op = gdsp_pkg::OP_HEAP_FIN;
        state_next = S_NB_RD;
      end
      S_NB_RD: begin
        ctl.op = gdsp_pkg::OP_NB_RD;
        state_next = st.nb_valid ? S_NB_UPD : S_NB_NEXT;
      end
      S_NB_UPD: begin
        ctl.op = gdsp_pkg::OP_NB_UPD;
        state_next = st.nb_push ? S_SU_RD : S_NB_NEXT;
      end
      S_SU_RD: begin
        ctl.op = gdsp_pkg::OP_SU_RD;
        state_next = st.su_root ? S_SU_FIN : S_SU_STEP;
      end
      S_SU_STEP: begin
        ctl.op = gdsp_pkg::OP_SU_STEP;
        state_next = st.su_move ? S_SU_RD : S_SU_FIN;
      end
      S_SU_FIN: begin
        ctl.op = gdsp_pkg::OP_HEAP_FIN;
        state_next = S_NB_NEXT;
      end
      S_NB_NEXT: begin
        ctl.op = gdsp_pkg::OP_DIR_NEXT;
        state_next = st.dir_last ? S_POP_RD : S_NB_RD;
      end
      S_Q_CAP: begin
        ctl.op = gdsp_pkg::OP_Q_CAP;
        state_next = st.q_hit_end ? S_OUT : S_QN_RD;
      end
      S_QN_RD: begin
        ctl.op = gdsp_pkg::OP_NB_RD;
        state_next = st.nb_valid ? S_QN_CMP : S_QN_NEXT;
      end
      S_QN_CMP: begin
        ctl.op = gdsp_pkg::OP_QN_CMP;
        state_next = st.qn_match ? S_OUT : S_QN_NEXT;
      end
      S_QN_NEXT: begin
        ctl.op = gdsp_pkg::OP_DIR_NEXT;
        state_next = st.dir_last ? S_OUT : S_QN_RD;
      end
      S_OUT: begin
        ctl.op = gdsp_pkg::OP_OUT;
        if (!st.out_busy) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[src/gdsp_datapath.sv]
// ----------------------------------------------------------------------------
// gdsp_datapath: grid stores, binary heap and working registers
// Executes one controller op per cycle; heap slots carry {distance, cell}.
// ----------------------------------------------------------------------------
module gdsp_datapath #(
  parameter int MAX_ROWS = gdsp_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = gdsp_pkg::MAX_COLS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  gdsp_pkg::dp_cmd_t              ctl,
  output gdsp_pkg::dp_status_t           st,
  input  gdsp_pkg::item_t                item,
  input  logic                           cfg_we,
  input  logic [gdsp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gdsp_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           result_stall,
  output logic                           result_valid,
  output gdsp_pkg::result_t              result
);

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int AW    = RW + CW;
  localparam int NCELL = 1 << AW;
  localparam int DW    = $clog2(2 * MAX_ROWS * MAX_COLS + 1);
  localparam int SW    = DW + AW;
  localparam int HCW   = AW + 1;
  localparam logic [6:0] ROWS_RST = 7'(MAX_ROWS < 64 ? MAX_ROWS : 64);
  localparam logic [6:0] COLS_RST = 7'(MAX_COLS < 64 ? MAX_COLS : 64);

  gdsp_pkg::item_t   word;
  gdsp_pkg::result_t res;
  logic [6:0]        rows, cols;
  logic              search_done;
  logic [AW-1:0]     start_cell, cnt, cur, nb, hi;
  logic [DW-1:0]     cur_d, qdist;
  logic [1:0]        dir;
  logic [HCW-1:0]    hcount;
  logic [SW-1:0]     v, lslot;
  logic              qcost_two;

  // memory ports
  logic [AW-1:0] k_addr, r_addr, d_addr, s_addr, p_addr;
  logic          k_we, r_we, d_we, s_we, p_we;
  logic [1:0]    k_wd, k_q;
  logic          r_wd, r_q;
  logic [DW-1:0] d_wd, d_q;
  logic [SW-1:0] s_wd, s_q;
  logic [AW-1:0] p_wd, p_q;

  gdsp_ram #(.WIDTH(2),  .DEPTH(NCELL)) u_kind  (.clk, .addr(k_addr), .we(k_we),
                                                .wdata(k_wd), .rdata(k_q));
  gdsp_ram #(.WIDTH(1),  .DEPTH(NCELL)) u_reach (.clk, .addr(r_addr), .we(r_we),
                                                .wdata(r_wd), .rdata(r_q));
  gdsp_ram #(.WIDTH(DW), .DEPTH(NCELL)) u_dist  (.clk, .addr(d_addr), .we(d_we),
                                                .wdata(d_wd), .rdata(d_q));
  gdsp_ram #(.WIDTH(SW), .DEPTH(NCELL)) u_slot  (.clk, .addr(s_addr), .we(s_we),
                                                .wdata(s_wd), .rdata(s_q));
  gdsp_ram #(.WIDTH(AW), .DEPTH(NCELL)) u_place (.clk, .addr(p_addr), .we(p_we),
                                                .wdata(p_wd), .rdata(p_q));

  // decode
  logic [8:0]    row_x, col_x;
  logic [AW-1:0] in_cell;
  logic          range_ok;
  logic [RW-1:0] cur_r;
  logic [CW-1:0] cur_c;
  logic          nb_valid;
  logic [AW-1:0] nb_addr;
  logic          blocked, nb_less;
  logic [DW-1:0] cost, nd;
  logic [AW+1:0] hi_x, l_idx, r_idx, cnt_x;
  logic          has_l, has_r, m_is_l, m_is_r, sd_move;
  logic [DW-1:0] md;
  logic [SW-1:0] m_slot;
  logic [AW-1:0] m_idx, parent;
  logic [HCW-1:0] hlast;
  logic          su_move, qn_match;
  logic [DW:0]   qsum;
  logic [31:0]   dq32;
  logic [13:0]   dsat;
  logic          out_busy;

  always_comb begin
    row_x    = 9'(word.row);
    col_x    = 9'(word.col);
    in_cell  = {row_x[RW-1:0], col_x[CW-1:0]};
    range_ok = (7'(word.row) < rows) && (7'(word.col) < cols);
    cur_r    = cur[AW-1:CW];
    cur_c    = cur[CW-1:0];
    unique case (dir)
      2'd0: begin
        nb_valid = (int'(cur_c) + 1) < int'(cols);
        nb_addr  = {cur_r, cur_c + 1'b1};
      end
      2'd1: begin
        nb_valid = (int'(cur_r) + 1) < int'(rows);
        nb_addr  = {cur_r + 1'b1, cur_c};
      end
      2'd2: begin
        nb_valid = (cur_r != '0);
        nb_addr  = {cur_r - 1'b1, cur_c};
      end
      default: begin
        nb_valid = (cur_c != '0);
        nb_addr  = {cur_r, cur_c - 1'b1};
      end
    endcase
    blocked = (k_q >= gdsp_pkg::KIND_BLOCKED);
    cost    = (k_q == gdsp_pkg::KIND_TWO) ? DW'(2) : DW'(1);
    nd      = cur_d + cost;
    nb_less = (nd < d_q);
    // heap children of hi, against the live count
    hi_x    = (AW + 2)'(hi);
    l_idx   = (hi_x << 1) + 1'b1;
    r_idx   = l_idx + 1'b1;
    cnt_x   = (AW + 2)'(hcount);
    has_l   = (l_idx < cnt_x);
    has_r   = (r_idx < cnt_x);
    m_is_l  = has_l && (lslot[SW-1:AW] < v[SW-1:AW]);
    md      = m_is_l ? lslot[SW-1:AW] : v[SW-1:AW];
    m_is_r  = has_r && (s_q[SW-1:AW] < md);
    sd_move = m_is_l || m_is_r;
    m_slot  = m_is_r ? s_q : lslot;
    m_idx   = m_is_r ? r_idx[AW-1:0] : l_idx[AW-1:0];
    parent  = (hi - 1'b1) >> 1;
    hlast   = hcount - 1'b1;
    su_move = (s_q[SW-1:AW] > v[SW-1:AW]);
    qsum    = {1'b0, d_q} + (qcost_two ? (DW + 1)'(2) : (DW + 1)'(1));
    qn_match = r_q && (qsum == {1'b0, qdist});
    dq32    = 32'(d_q);
    dsat    = (dq32 > 32'(gdsp_pkg::DIST_SAT)) ? gdsp_pkg::DIST_SAT : dq32[13:0];
    out_busy = result_valid && result_stall;
  end

  always_comb begin
    st.cmd         = word.cmd;
    st.range_ok    = range_ok;
    st.search_done = search_done;
    st.clr_last    = (cnt == '1);
    st.blocked     = blocked;
    st.heap_empty  = (hcount == '0);
    st.heap_one    = (hcount == HCW'(1));
    st.sd_no_l     = !has_l;
    st.sd_move     = sd_move;
    st.nb_valid    = nb_valid;
    st.nb_push     = !blocked && (!r_q || nb_less);
    st.su_root     = (hi == '0);
    st.su_move     = su_move;
    st.dir_last    = (dir == 2'd3);
    st.q_hit_end   = !r_q || (cur == start_cell);
    st.qn_match    = qn_match;
    st.out_busy    = out_busy;
  end

  // memory port steering
  always_comb begin
    k_addr = nb_addr; k_we = 1'b0; k_wd = gdsp_pkg::KIND_ONE;
    r_addr = nb_addr; r_we = 1'b0; r_wd = 1'b0;
    d_addr = nb;      d_we = 1'b0; d_wd = nd;
    s_addr = hi;      s_we = 1'b0; s_wd = v;
    p_addr = nb_addr; p_we = 1'b0; p_wd = hi;
    unique case (ctl.op)
      gdsp_pkg::OP_LOAD: begin
        k_addr = in_cell;
        k_we   = 1'b1;
        k_wd   = (word.cell_kind > gdsp_pkg::KIND_BLOCKED) ?
                 gdsp_pkg::KIND_BLOCKED : word.cell_kind;
      end
      gdsp_pkg::OP_KCLR: begin
        k_addr = cnt;
        k_we   = 1'b1;
      end
      gdsp_pkg::OP_RCLR: begin
        r_addr = cnt;
        r_we   = 1'b1;
      end
      gdsp_pkg::OP_START_RD: begin
        k_addr = in_cell;
      end
      gdsp_pkg::OP_START_SET: begin
        d_addr = in_cell; d_we = !blocked; d_wd = cost;
        r_addr = in_cell; r_we = !blocked; r_wd = 1'b1;
        s_addr = '0;      s_we = !blocked; s_wd = {cost, in_cell};
        p_addr = in_cell; p_we = !blocked; p_wd = '0;
      end
      gdsp_pkg::OP_POP_RD:  s_addr = '0;
      gdsp_pkg::OP_POP_TOP: s_addr = hlast[AW-1:0];
      gdsp_pkg::OP_SD_RDL:  s_addr = l_idx[AW-1:0];
      gdsp_pkg::OP_SD_RDR:  s_addr = r_idx[AW-1:0];
      gdsp_pkg::OP_SD_STEP: begin
        s_we = sd_move; s_wd = m_slot;
        p_addr = m_slot[AW-1:0]; p_we = sd_move;
      end
      gdsp_pkg::OP_HEAP_FIN: begin
        s_we = 1'b1;
        p_addr = v[AW-1:0]; p_we = 1'b1;
      end
      gdsp_pkg::OP_NB_RD: begin
        d_addr = nb_addr;
      end
      gdsp_pkg::OP_NB_UPD: begin
        r_addr = nb; r_we = !blocked && !r_q; r_wd = 1'b1;
        d_we   = !blocked && (!r_q || nb_less);
      end
      gdsp_pkg::OP_SU_RD: s_addr = parent;
      gdsp_pkg::OP_SU_STEP: begin
        s_we = su_move; s_wd = s_q;
        p_addr = s_q[AW-1:0]; p_we = su_move;
      end
      gdsp_pkg::OP_Q_RD: begin
        k_addr = in_cell;
        r_addr = in_cell;
        d_addr = in_cell;
      end
      default: ;
    endcase
  end

  logic [6:0] cfg_v;
  always_comb begin
    cfg_v = (cfg_data == '0) ? 7'd1 : cfg_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows         <= ROWS_RST;
      cols         <= COLS_RST;
      search_done  <= 1'b0;
      cnt          <= '0;
      hcount       <= '0;
      result_valid <= 1'b0;
    end else begin
      // a word leaving while a new one loads keeps valid high
      if (result_valid && !result_stall && ctl.op != gdsp_pkg::OP_OUT) result_valid <= 1'b0;
      unique case (ctl.op)
        gdsp_pkg::OP_IDLE: begin
          if (ctl.take) word <= item;
        end
        gdsp_pkg::OP_RES_ZERO: res <= '0;
        gdsp_pkg::OP_RES_ST1: begin
          res <= '{status: gdsp_pkg::ST_RANGE, reachable: 1'b0, distance: '0,
                   pred_dir: gdsp_pkg::PRED_NONE};
        end
        gdsp_pkg::OP_RES_ST2: begin
          res <= '{status: gdsp_pkg::ST_NO_RUN, reachable: 1'b0, distance: '0,
                   pred_dir: gdsp_pkg::PRED_NONE};
        end
        gdsp_pkg::OP_LOAD: begin
          search_done <= 1'b0;
          res         <= '0;
        end
        gdsp_pkg::OP_KCLR, gdsp_pkg::OP_RCLR: cnt <= cnt + 1'b1;
        gdsp_pkg::OP_START_RD: begin
          search_done <= 1'b1;
          start_cell  <= in_cell;
          hcount      <= '0;
        end
        gdsp_pkg::OP_START_SET: begin
          if (!blocked) hcount <= HCW'(1);
        end
        gdsp_pkg::OP_POP_TOP: begin
          cur    <= s_q[AW-1:0];
          cur_d  <= s_q[SW-1:AW];
          hcount <= hlast;
          dir    <= 2'd0;
        end
        gdsp_pkg::OP_POP_LAST: begin
          v  <= s_q;
          hi <= '0;
        end
        gdsp_pkg::OP_SD_RDR: lslot <= s_q;
        gdsp_pkg::OP_SD_STEP: begin
          if (sd_move) hi <= m_idx;
        end
        gdsp_pkg::OP_NB_RD: nb <= nb_addr;
        gdsp_pkg::OP_NB_UPD: begin
          if (!blocked) begin
            if (!r_q) begin
              v      <= {nd, nb};
              hi     <= hcount[AW-1:0];
              hcount <= hcount + 1'b1;
            end else if (nb_less) begin
              v  <= {nd, nb};
              hi <= p_q;
            end
          end
        end
        gdsp_pkg::OP_SU_STEP: begin
          if (su_move) hi <= parent;
        end
        gdsp_pkg::OP_DIR_NEXT: dir <= dir + 1'b1;
        gdsp_pkg::OP_Q_RD: begin
          cur <= in_cell;
          dir <= 2'd0;
        end
        gdsp_pkg::OP_Q_CAP: begin
          qdist     <= d_q;
          qcost_two <= (k_q == gdsp_pkg::KIND_TWO);
          if (r_q) begin
            res <= '{status: gdsp_pkg::ST_OK, reachable: 1'b1, distance: dsat,
                     pred_dir: gdsp_pkg::PRED_NONE};
          end else begin
            res <= '0;
          end
        end
        gdsp_pkg::OP_QN_CMP: begin
          if (qn_match) res.pred_dir <= 3'(dir) + 3'd1;
        end
        gdsp_pkg::OP_OUT: begin
          if (!out_busy) begin
            result       <= res;
            result_valid <= 1'b1;
          end
        end
        default: ;
      endcase
      // the user must make register writes arrive only while idle; the block does not enforce it
      if (cfg_we) begin
        if (cfg_index == gdsp_pkg::REG_NUM_ROWS) begin
          rows <= (int'(cfg_v) > MAX_ROWS) ? 7'(MAX_ROWS) : cfg_v;
        end else begin
          cols <= (int'(cfg_v) > MAX_COLS) ? 7'(MAX_COLS) : cfg_v;
        end
        search_done <= 1'b0;
      end
    end
  end

endmodule

[src/grid_dijkstra_shortest_path_core.sv]
// ----------------------------------------------------------------------------
// grid_dijkstra_shortest_path_core: grid shortest-path engine, top level
// Dijkstra over a loaded cost grid with a binary min-heap and decrease-key.
// ----------------------------------------------------------------------------
// Usage:
//  - item channel (item_valid/item_stall/item): one command word per item:
//    load a cell kind, run a search from a start cell, or query a cell.
//  - result channel (result_valid/result_stall/result): exactly one word per
//    item, in order. A finished word waits in the output register while the
//    next item is taken; the sequencer holds only when a second word is done
//    before the first one leaves.
//  - cfg port (cfg_we/cfg_index/cfg_data): num_rows (0), num_cols (1); write
//    only while idle. A write invalidates the last search.
// Sequence:
//  - load, out-of-range, query-before-run and idle-command items: the result
//    word is set at dispatch and then sent to the output register.
//  - query: reads the cell, then tries neighbors in turn for the predecessor.
//  - run: clears the reached flag of every cell, then per visited cell a heap
//    pop and sift-down, and per neighbor tried a relax with a sift-up when
//    the neighbor is pushed or its distance lowers.
// Reset: rst (synchronous) starts a pass that sets every cell to cost one;
// item_stall stays high until it ends.
// ----------------------------------------------------------------------------
module grid_dijkstra_shortest_path_core #(
  parameter int MAX_ROWS = gdsp_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = gdsp_pkg::MAX_COLS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  gdsp_pkg::item_t                item,
  output logic                           result_valid,
  input  logic                           result_stall,
  output gdsp_pkg::result_t              result,
  input  logic                           cfg_we,
  input  logic [gdsp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gdsp_pkg::CFG_W-1:0]     cfg_data
);

  gdsp_pkg::dp_cmd_t    ctl;  // op for this cycle, from the sequencer
  gdsp_pkg::dp_status_t st;   // branch flags back from the datapath

  gdsp_ctrl u_ctrl (
    .clk,
    .rst,
    .item_valid,
    .item_stall,
    .st,
    .ctl
  );

  gdsp_datapath #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_dp (
    .clk,
    .rst,
    .ctl,
    .st,
    .item,
    .cfg_we,
    .cfg_index,
    .cfg_data,
    .result_stall,
    .result_valid,
    .result
  );

endmodule

[src/gdsp_checker.sv]
// ----------------------------------------------------------------------------
// gdsp_checker: port-level assertions for the grid shortest-path core
// Output handshake, input take and result word consistency.
// ----------------------------------------------------------------------------
module gdsp_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input logic              result_valid,
  input logic              result_stall,
  input gdsp_pkg::result_t result
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result word dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(result))
    else $error("result word changed while stalled");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("second item taken before the first was dispatched");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.status != 2'd3)
    else $error("undefined status code");

  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status != gdsp_pkg::ST_OK || !result.reachable) |->
    !result.reachable && result.distance == '0 &&
    result.pred_dir == gdsp_pkg::PRED_NONE)
    else $error("fields set on a word without a reachable cell");

endmodule

bind grid_dijkstra_shortest_path_core gdsp_checker u_chk (.*);

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking testbench for grid_dijkstra_shortest_path_core
// Drives load, run and query words over the valid/stall item channel. The
// testbench keeps its own copy of the grid and a shortest-path solver, and
// checks every result word in order. A directed table runs first, then random
// phases that each set a grid size. Channels idle at random in all but two.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NR          = gdsp_pkg::MAX_ROWS_DEF;
  localparam int NC          = gdsp_pkg::MAX_COLS_DEF;
  localparam int NCELL       = NR * NC;
  // A full 64x64 search runs with both channels quiet.
  localparam int STALL_LIMIT = 4000000;
  localparam int NUM_PHASES  = 16;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           item_valid = 1'b0;
  logic                           item_stall;
  gdsp_pkg::item_t                item = '0;
  logic                           result_valid;
  logic                           result_stall = 1'b0;
  gdsp_pkg::result_t              result;
  logic                           cfg_we = 1'b0;
  logic [gdsp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [gdsp_pkg::CFG_W-1:0]     cfg_data = '0;

  grid_dijkstra_shortest_path_core DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow copy of the grid and the last search
  // --------------------------------------------------------------------------
  logic [1:0]  kind_mem [NCELL];
  int unsigned dist_mem [NCELL];
  bit          reached  [NCELL];
  int          start_idx;
  bit          solved;
  int          rows_used;
  int          cols_used;

  gdsp_pkg::result_t pending_results [$];   // expected words, oldest first
  int          err_count;
  bit          idle_on;
  int          words_sent, search_count, hit_count, range_count;

  function automatic int cost_of(int idx);
    return (kind_mem[idx] == gdsp_pkg::KIND_TWO) ? 2 : 1;
  endfunction

  // Neighbor order: col+1, row+1, row-1, col-1 (pred_dir 1..4).
  function automatic bit step_to(int r, int c, int d, output int nb);
    int nr, nc;
    nr = r + ((d == 1) ? 1 : (d == 2) ? -1 : 0);
    nc = c + ((d == 0) ? 1 : (d == 3) ? -1 : 0);
    nb = nr * NC + nc;
    return !(nr < 0 || nc < 0 || nr >= rows_used || nc >= cols_used);
  endfunction

  // Label-correcting search; final distances match any exact Dijkstra.
  function automatic void grid_solve(int r, int c);
    int frontier [$];
    int cur, nb, d;
    int unsigned nd;
    foreach (reached[i]) reached[i] = 1'b0;
    start_idx = r * NC + c;
    solved    = 1'b1;
    if (kind_mem[start_idx] >= gdsp_pkg::KIND_BLOCKED) return;
    dist_mem[start_idx] = cost_of(start_idx);
    reached[start_idx]  = 1'b1;
    frontier.push_back(start_idx);
    while (frontier.size() > 0) begin
      cur = frontier.pop_front();
      for (d = 0; d < 4; d++) begin
        if (!step_to(cur / NC, cur % NC, d, nb)) continue;
        if (kind_mem[nb] >= gdsp_pkg::KIND_BLOCKED) continue;
        nd = dist_mem[cur] + cost_of(nb);
        if (!reached[nb] || nd < dist_mem[nb]) begin
          reached[nb]  = 1'b1;
          dist_mem[nb] = nd;
          frontier.push_back(nb);
        end
      end
    end
  endfunction

  function automatic gdsp_pkg::result_t grid_step(gdsp_pkg::item_t w);
    gdsp_pkg::result_t res;
    int idx, nb, d;
    res = '0;
    if (w.cmd == gdsp_pkg::CMD_NONE) return res;
    if (w.row >= rows_used || w.col >= cols_used) begin
      res.status = gdsp_pkg::ST_RANGE;
      return res;
    end
    idx = w.row * NC + w.col;
    if (w.cmd == gdsp_pkg::CMD_LOAD) begin
      kind_mem[idx] = (w.cell_kind > gdsp_pkg::KIND_BLOCKED) ?
                      gdsp_pkg::KIND_BLOCKED : w.cell_kind;
      solved = 1'b0;
      return res;
    end
    if (w.cmd == gdsp_pkg::CMD_RUN) begin
      grid_solve(w.row, w.col);
      return res;
    end
    if (!solved) begin
      res.status = gdsp_pkg::ST_NO_RUN;
      return res;
    end
    if (!reached[idx]) return res;
    res.reachable = 1'b1;
    res.distance  = (dist_mem[idx] > gdsp_pkg::DIST_SAT) ?
                    gdsp_pkg::DIST_SAT : 14'(dist_mem[idx]);
    if (idx != start_idx) begin
      for (d = 0; d < 4; d++) begin
        if (!step_to(w.row, w.col, d, nb)) continue;
        if (!reached[nb]) continue;
        if (dist_mem[nb] + cost_of(idx) == dist_mem[idx]) begin
          res.pred_dir = 3'(d + 1);
          break;
        end
      end
    end
    return res;
  endfunction

  function automatic void set_dim(bit is_cols, int v);
    int lim;
    v   = v & 8'h7F;
    lim = is_cols ? NC : NR;
    if (v == 0) v = 1;
    if (v > lim) v = lim;
    if (is_cols) cols_used = v;
    else rows_used = v;
    solved = 1'b0;
  endfunction

  function automatic gdsp_pkg::result_t mk_res(logic [1:0] st, logic rch, int dval,
                                               logic [2:0] pd);
    gdsp_pkg::result_t res;
    res.status    = st;
    res.reachable = rch;
    res.distance  = 14'(dval);
    res.pred_dir  = pd;
    return res;
  endfunction

  function automatic gdsp_pkg::item_t mk_word(logic [1:0] cmd, int r, int c, logic [1:0] k);
    gdsp_pkg::item_t w;
    w.cmd       = cmd;
    w.row       = 6'(r);
    w.col       = 6'(c);
    w.cell_kind = k;
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  // Hold the word until taken, then log the expected result. Valid is only
  // lowered when an idle gap follows, so back-to-back words keep it high.
  task automatic send_word(gdsp_pkg::item_t w, bit fixed, gdsp_pkg::result_t fixed_res);
    gdsp_pkg::result_t res;
    item_valid <= 1'b1;
    item       <= w;
    do @(posedge clk); while (item_stall);
    res = grid_step(w);
    pending_results.push_back(fixed ? fixed_res : res);
    words_sent++;
    if (w.cmd == gdsp_pkg::CMD_RUN && res.status == gdsp_pkg::ST_OK) search_count++;
    if (res.status == gdsp_pkg::ST_RANGE) range_count++;
    if (res.reachable) hit_count++;
    if (idle_on && $urandom_range(0, 99) < 21) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic send_pred(gdsp_pkg::item_t w);
    send_word(w, 1'b0, '0);
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Both registers in one burst; write enable stays high across the pair.
  task automatic write_dims(int r, int c);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= gdsp_pkg::REG_NUM_ROWS;
    cfg_data  <= 7'(r);
    @(posedge clk);
    cfg_index <= gdsp_pkg::REG_NUM_COLS;
    cfg_data  <= 7'(c);
    @(posedge clk);
    cfg_we    <= 1'b0;
    set_dim(1'b0, r);
    set_dim(1'b1, c);
    @(posedge clk);
  endtask

  function automatic logic [1:0] rand_kind();
    int k;
    k = $urandom_range(0, 9);
    return (k < 5) ? gdsp_pkg::KIND_ONE : (k < 8) ? gdsp_pkg::KIND_TWO :
           (k < 9) ? gdsp_pkg::KIND_BLOCKED : 2'd3;
  endfunction

  function automatic gdsp_pkg::item_t rand_in_grid(logic [1:0] cmd);
    return mk_word(cmd, $urandom_range(0, rows_used - 1), $urandom_range(0, cols_used - 1),
                   (cmd == gdsp_pkg::CMD_LOAD) ? rand_kind() : 2'($urandom_range(0, 3)));
  endfunction

  // One grid setting: seed some cells, search if allowed, then a random mix of words.
  task automatic run_phase(int r, int c, int n, bit allow_run, bit pause_mid);
    gdsp_pkg::item_t w;
    int    pick, nr, nc;
    write_dims(r, c);
    repeat ((rows_used * cols_used < 10) ? rows_used * cols_used : 10)
      send_pred(rand_in_grid(gdsp_pkg::CMD_LOAD));
    if (allow_run) send_pred(rand_in_grid(gdsp_pkg::CMD_RUN));
    for (int i = 0; i < n; i++) begin
      if (pause_mid && i == n / 2) wait_drained();
      pick = $urandom_range(0, 99);
      if (pick < 45) w = rand_in_grid(gdsp_pkg::CMD_QUERY);
      else if (pick < 60) w = rand_in_grid(gdsp_pkg::CMD_LOAD);
      else if (pick < 65)
        w = rand_in_grid(allow_run ? gdsp_pkg::CMD_RUN : gdsp_pkg::CMD_QUERY);
      else if (pick < 77) begin
        // coordinate past the grid in use when it is under 64x64, any real command
        nr = $urandom_range(0, 63);
        nc = $urandom_range(0, 63);
        if (rows_used < NR && (cols_used == NC || $urandom_range(0, 1)))
          nr = $urandom_range(rows_used, 63);
        else if (cols_used < NC)
          nc = $urandom_range(cols_used, 63);
        w = mk_word(2'($urandom_range(0, 2)), nr, nc, 2'($urandom_range(0, 3)));
        if (!allow_run && w.cmd == gdsp_pkg::CMD_RUN) w.cmd = gdsp_pkg::CMD_QUERY;
      end
      else if (pick < 82)
        w = mk_word(gdsp_pkg::CMD_NONE, $urandom_range(0, 63), $urandom_range(0, 63),
                    2'($urandom_range(0, 3)));
      else
        w = mk_word(gdsp_pkg::CMD_QUERY, $urandom_range(0, 63), $urandom_range(0, 63),
                    2'($urandom_range(0, 3)));
      send_pred(w);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result checker and receiver stall
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    gdsp_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word %h", $realtime, result);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (result.status !== want.status) begin
          $display("%0t: status exp %0d got %0d", $realtime, want.status, result.status);
          err_count++;
        end
        if (result.reachable !== want.reachable) begin
          $display("%0t: reachable exp %0d got %0d", $realtime, want.reachable,
                   result.reachable);
          err_count++;
        end
        if (result.distance !== want.distance) begin
          $display("%0t: distance exp %0d got %0d", $realtime, want.distance, result.distance);
          err_count++;
        end
        if (result.pred_dir !== want.pred_dir) begin
          $display("%0t: pred_dir exp %0d got %0d", $realtime, want.pred_dir, result.pred_dir);
          err_count++;
        end
      end
    end
    result_stall <= idle_on && ($urandom_range(0, 99) < 21);
  end

  // Watchdog: quiet cycles on both channels.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog expired, %0d words outstanding", $realtime,
               pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Directed table
  // --------------------------------------------------------------------------
  typedef struct {
    gdsp_pkg::item_t   w;
    bit                fixed;
    gdsp_pkg::result_t res;
  } dir_row_t;

  dir_row_t dir_tab [$];

  task automatic build_table();
    // query before any search
    dir_tab.push_back('{mk_word(gdsp_pkg::CMD_QUERY, 0, 0, gdsp_pkg::KIND_ONE), 1,
                        mk_res(gdsp_pkg::ST_NO_RUN, 0, 0, 0)});
    dir_tab.push_back('{mk_word(gdsp_pkg::CMD_NONE, 63, 63, 2'd3), 1,
                        mk_res(gdsp_pkg::ST_OK, 0, 0, 0)});
    // full open grid from the far corner: distance is Manhattan + 1
    dir_tab.push_back('{mk_word(gdsp_pkg::CMD_RUN, 63, 63, gdsp_pkg::KIND_ONE), 1,
                        mk_res(gdsp_pkg::ST_OK, 0, 0, 0)});
    dir_tab.push_back('{mk_word(gdsp_pkg::CMD_QUERY, 0, 0, gdsp_pkg::KIND_ONE), 1,
                        mk_res(gdsp_pkg::ST_OK, 1, 127, 1)});
    dir_tab.push_back('{mk_word(gdsp_pkg::CMD_QUERY, 63, 63, gdsp_pkg::KIND_ONE), 1,
                        mk_res(gdsp_pkg::ST_OK, 1, 1, gdsp_pkg::PRED_NONE)});
    dir_tab.push_back('{mk_word(gdsp_pkg::CMD_QUERY, 0, 63, gdsp_pkg::KIND_ONE), 1,
                        mk_res(gdsp_pkg::ST_OK, 1, 64, 2)});
    dir_tab.push_back('{mk_word(gdsp_pkg::CMD_QUERY, 63, 0, gdsp_pkg::KIND_ONE), 1,
                        mk_res(gdsp_pkg::ST_OK, 1, 64, 1)});
    dir_tab.push_back('{mk_word(gdsp_pkg::CMD_QUERY, 31, 32, gdsp_pkg::KIND_TWO), 0, '0});
    // a load drops the last search
    dir_tab.push_back('{mk_word(gdsp_pkg::CMD_LOAD, 0, 0, gdsp_pkg::KIND_TWO), 1,
                        mk_res(gdsp_pkg::ST_OK, 0, 0, 0)});
    dir_tab.push_back('{mk_word(gdsp_pkg::CMD_QUERY, 0, 0, gdsp_pkg::KIND_ONE), 1,
                        mk_res(gdsp_pkg::ST_NO_RUN, 0, 0, 0)});
    // kind 3 is stored as blocked; a blocked start reaches nothing
    dir_tab.push_back('{mk_word(gdsp_pkg::CMD_LOAD, 5, 5, 2'd3), 0, '0});
    dir_tab.push_back('{mk_word(gdsp_pkg::CMD_LOAD, 5, 6, gdsp_pkg::KIND_BLOCKED), 0, '0});
    dir_tab.push_back('{mk_word(gdsp_pkg::CMD_RUN, 5, 5, gdsp_pkg::KIND_ONE), 1,
                        mk_res(gdsp_pkg::ST_OK, 0, 0, 0)});
    dir_tab.push_back('{mk_word(gdsp_pkg::CMD_QUERY, 5, 5, gdsp_pkg::KIND_ONE), 1,
                        mk_res(gdsp_pkg::ST_OK, 0, 0, 0)});
    dir_tab.push_back('{mk_word(gdsp_pkg::CMD_QUERY, 0, 0, gdsp_pkg::KIND_ONE), 1,
                        mk_res(gdsp_pkg::ST_OK, 0, 0, 0)});
    dir_tab.push_back('{mk_word(gdsp_pkg::CMD_LOAD, 63, 63, gdsp_pkg::KIND_ONE), 1,
                        mk_res(gdsp_pkg::ST_OK, 0, 0, 0)});
    dir_tab.push_back('{mk_word(gdsp_pkg::CMD_LOAD, 5, 6, gdsp_pkg::KIND_ONE), 0, '0});
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  // First phases hit the register extremes: 0 reads as 1, 127 clamps to 64.
  int phase_rows [6] = '{0, 1, 127, 64, 3, 8};
  int phase_cols [6] = '{127, 1, 0, 2, 5, 8};

  initial begin
    foreach (kind_mem[i]) begin
      kind_mem[i] = gdsp_pkg::KIND_ONE;
      dist_mem[i] = 0;
      reached[i]  = 1'b0;
    end
    start_idx = 0;
    solved    = 1'b0;
    rows_used = NR;
    cols_used = NC;
    err_count = 0;
    idle_on   = 1'b1;
    words_sent = 0;
    search_count = 0;
    hit_count = 0;
    range_count = 0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    build_table();
    foreach (dir_tab[i]) send_word(dir_tab[i].w, dir_tab[i].fixed, dir_tab[i].res);

    for (int p = 0; p < NUM_PHASES; p++) begin
      idle_on = !(p == 6 || p == 7);   // long stretch with no idling
      if (p < 6) run_phase(phase_rows[p], phase_cols[p], 30, 1'b1, p == 2);
      else if (p < NUM_PHASES - 1)
        run_phase($urandom_range(2, 8), $urandom_range(2, 8), 30, 1'b1, 1'b0);
      else
        run_phase(64, 64, 20, 1'b0, 1'b0);   // full size, no search: too slow
    end
    idle_on = 1'b1;

    wait_drained();
    repeat (50) @(posedge clk);
    $display("Sent %0d words over %0d grid sizes: %0d searches, %0d reached-cell queries,",
             words_sent, NUM_PHASES + 1, search_count, hit_count);
    $display("%0d out-of-range words, %0d mismatches.", range_count, err_count);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
